// ===== design/scpd_pkg.sv =====
// Shared types and constants of the sampled color presence detector.
// Used by the divider, the datapath, the controller and the top level.
package scpd_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 48;
	localparam int unsigned FIELD_W    = 16;
	localparam int unsigned ACC_W      = 32;
	localparam int unsigned DIVD_W     = 32;
	localparam int unsigned DIVR_W     = 16;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned SQ_W       = 16;
	localparam int unsigned PROD_W     = 32;
	localparam int unsigned DIST_W     = 34;
	localparam int unsigned NUM_CHAN   = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HSV      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_FACTORS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_RANGE         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_RANGE         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WEIGHT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_BOUND    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS      = 3'd7;

	localparam logic [FIELD_W-1:0] MAX_WEIGHT_RST   = 16'd1;
	localparam logic [FIELD_W-1:0] SAMPLE_COUNT_RST = 16'd1;
	localparam logic [FIELD_W-1:0] FRAME_COLS_RST   = 16'd640;

	// A distance of 1.0 in Q18.16.
	localparam logic [DIST_W-1:0] DIST_ONE = 34'd65536;

	typedef struct packed {
		logic lat_load;
		logic div_start;
		logic div_sel;
		logic step_cap;
		logic split_cap;
		logic pix_load;
		logic adv_pos;
		logic adv_sample;
		logic take;
		logic frame_clear;
		logic out_load;
	} scpd_cmd_t;

	typedef struct packed {
		logic pending_hit;
		logic pending_skip;
		logic in_eof;
		logic pix_eof;
		logic div_done;
	} scpd_stat_t;

endpackage

// ===== design/scpd_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on scpd_pkg for operand widths.
module scpd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [scpd_pkg::DIVD_W-1:0]  dividend,
	input  logic [scpd_pkg::DIVR_W-1:0]  divisor,
	output logic                         done,
	output logic [scpd_pkg::DIVD_W-1:0]  quotient,
	output logic [scpd_pkg::DIVR_W-1:0]  remainder
);
	import scpd_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [DIVR_W:0]   shifted;
	logic [DIVR_W:0]   diff;
	logic              ge;

	assign shifted = {rem_q, quo_q[DIVD_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIVD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== design/scpd_datapath.sv =====
// Datapath: configuration registers, region setup, sample tracking, color weighting,
// accumulation and the result register. Depends on scpd_pkg and scpd_div.
module scpd_datapath #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [scpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [scpd_pkg::CHAN_W-1:0]     pixel_hue,
	input  logic [scpd_pkg::CHAN_W-1:0]     pixel_sat,
	input  logic [scpd_pkg::CHAN_W-1:0]     pixel_val,
	input  logic                            end_of_frame,
	input  scpd_pkg::scpd_cmd_t             cmd,
	output scpd_pkg::scpd_stat_t            st,
	output logic [scpd_pkg::ACC_W-1:0]      weight_total,
	output logic                            color_present,
	output logic [scpd_pkg::FIELD_W-1:0]    samples_seen
);
	import scpd_pkg::*;

	// Configuration registers.
	logic [NUM_CHAN*CHAN_W-1:0]  target_hsv_q;
	logic [NUM_CHAN*FIELD_W-1:0] channel_factors_q;
	logic [2*FIELD_W-1:0]        x_range_q;
	logic [2*FIELD_W-1:0]        y_range_q;
	logic [FIELD_W-1:0]          max_weight_q;
	logic [ACC_W-1:0]            detect_bound_q;
	logic [FIELD_W-1:0]          sample_count_q;
	logic [FIELD_W-1:0]          frame_cols_q;

	// Latched region and sample tracking.
	logic [FIELD_W-1:0]    lat_col0_q;
	logic [FIELD_W-1:0]    lat_row0_q;
	logic [FIELD_W-1:0]    lat_width_q;
	logic [FIELD_W-1:0]    lat_count_q;
	logic [ACC_W-1:0]      area_q;
	logic [FIELD_W-1:0]    step_q;
	logic [FIELD_W-1:0]    step_rows_q;
	logic [FIELD_W-1:0]    step_cols_q;
	logic [FIELD_W-1:0]    sample_index_q;
	logic [FIELD_W-1:0]    col_off_q;
	logic [COORD_BITS-1:0] row_off_q;

	// Raster position and frame totals.
	logic [COORD_BITS-1:0] column_counter_q;
	logic [COORD_BITS-1:0] row_counter_q;
	logic [FIELD_W-1:0]    samples_taken_q;
	logic [ACC_W-1:0]      weight_accumulator_q;

	// Held pixel and weighting pipeline.
	logic [NUM_CHAN*CHAN_W-1:0] pix_q;
	logic                       pix_eof_q;
	logic [SQ_W-1:0]            sq_s1   [NUM_CHAN];
	logic [PROD_W-1:0]          prod_s2 [NUM_CHAN];
	logic [FIELD_W-1:0]         weight_s3;

	logic [ACC_W-1:0]   weight_total_q;
	logic               color_present_q;
	logic [FIELD_W-1:0] samples_seen_q;

	logic [FIELD_W-1:0]    width_d;
	logic [FIELD_W-1:0]    height_d;
	logic [ACC_W-1:0]      area_d;
	logic [FIELD_W-1:0]    col_sum;
	logic [COORD_BITS-1:0] next_sample_col;
	logic [COORD_BITS-1:0] next_sample_row;
	logic                  pending;
	logic                  unreach;
	logic                  behind;
	logic                  hit;
	logic [FIELD_W:0]      col_adv;
	logic                  off_wrap;
	logic [FIELD_W:0]      col_inc;
	logic                  row_wrap;
	logic [DIST_W-1:0]     color_dist;
	logic [DIVD_W-1:0]     div_dividend;
	logic [DIVR_W-1:0]     div_divisor;
	logic                  div_done;
	logic [DIVD_W-1:0]     div_quo;
	logic [DIVR_W-1:0]     div_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_hsv_q      <= '0;
			channel_factors_q <= '0;
			x_range_q         <= '0;
			y_range_q         <= '0;
			max_weight_q      <= MAX_WEIGHT_RST;
			detect_bound_q    <= '0;
			sample_count_q    <= SAMPLE_COUNT_RST;
			frame_cols_q      <= FRAME_COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_HSV:      target_hsv_q      <= cfg_data[NUM_CHAN*CHAN_W-1:0];
				REG_CHANNEL_FACTORS: channel_factors_q <= cfg_data[NUM_CHAN*FIELD_W-1:0];
				REG_X_RANGE:         x_range_q         <= cfg_data[2*FIELD_W-1:0];
				REG_Y_RANGE:         y_range_q         <= cfg_data[2*FIELD_W-1:0];
				REG_MAX_WEIGHT:      max_weight_q      <= cfg_data[FIELD_W-1:0];
				REG_DETECT_BOUND:    detect_bound_q    <= cfg_data[ACC_W-1:0];
				REG_SAMPLE_COUNT:    sample_count_q    <= cfg_data[FIELD_W-1:0];
				REG_FRAME_COLS:      frame_cols_q      <= cfg_data[FIELD_W-1:0];
			endcase
		end
	end

	// Region setup arithmetic.
	assign width_d  = x_range_q[2*FIELD_W-1:FIELD_W] - x_range_q[FIELD_W-1:0];
	assign height_d = y_range_q[2*FIELD_W-1:FIELD_W] - y_range_q[FIELD_W-1:0];
	assign area_d   = ACC_W'(width_d) * ACC_W'(height_d);

	assign div_dividend = cmd.div_sel ? DIVD_W'(step_q) : area_q;
	assign div_divisor  = cmd.div_sel ? lat_width_q : lat_count_q;

	scpd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.lat_load) begin
			lat_col0_q <= x_range_q[FIELD_W-1:0];
			lat_row0_q <= y_range_q[FIELD_W-1:0];
			area_q     <= area_d;
		end
		if (cmd.step_cap) begin
			step_q <= (lat_count_q == '0) ? '0 : div_quo[FIELD_W-1:0];
		end
		if (cmd.split_cap) begin
			step_rows_q <= (lat_width_q == '0) ? '0 : div_quo[FIELD_W-1:0];
			step_cols_q <= (lat_width_q == '0) ? '0 : div_rem;
		end
	end

	// Position of the pending sample and its relation to the raster position.
	assign col_sum         = col_off_q + lat_col0_q;
	assign next_sample_col = col_sum[COORD_BITS-1:0];
	assign next_sample_row = row_off_q + lat_row0_q[COORD_BITS-1:0];

	assign pending = sample_index_q < lat_count_q;
	assign unreach = FIELD_W'(next_sample_col) >= frame_cols_q;
	assign behind  = (next_sample_row < row_counter_q) ||
		((next_sample_row == row_counter_q) && (next_sample_col < column_counter_q));
	assign hit     = (next_sample_row == row_counter_q) && (next_sample_col == column_counter_q);

	// Offset of the following sample; the column offset folds into a row carry.
	assign col_adv  = (FIELD_W+1)'(col_off_q) + (FIELD_W+1)'(step_cols_q);
	assign off_wrap = (col_adv >= (FIELD_W+1)'(lat_width_q)) && (lat_width_q != '0);

	assign col_inc  = (FIELD_W+1)'(column_counter_q) + (FIELD_W+1)'(1);
	assign row_wrap = col_inc >= (FIELD_W+1)'(frame_cols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_width_q          <= '0;
			lat_count_q          <= '0;
			sample_index_q       <= '0;
			col_off_q            <= '0;
			row_off_q            <= '0;
			column_counter_q     <= '0;
			row_counter_q        <= '0;
			samples_taken_q      <= '0;
			weight_accumulator_q <= '0;
		end else begin
			if (cmd.lat_load) begin
				lat_width_q    <= width_d;
				lat_count_q    <= sample_count_q;
				sample_index_q <= '0;
				col_off_q      <= '0;
				row_off_q      <= '0;
			end else if (cmd.adv_sample) begin
				sample_index_q <= sample_index_q + FIELD_W'(1);
				col_off_q      <= off_wrap ? FIELD_W'(col_adv - (FIELD_W+1)'(lat_width_q))
					: col_adv[FIELD_W-1:0];
				row_off_q      <= row_off_q + step_rows_q[COORD_BITS-1:0]
					+ COORD_BITS'(off_wrap);
			end
			if (cmd.frame_clear) begin
				column_counter_q     <= '0;
				row_counter_q        <= '0;
				samples_taken_q      <= '0;
				weight_accumulator_q <= '0;
			end else begin
				if (cmd.adv_pos) begin
					if (row_wrap) begin
						column_counter_q <= '0;
						row_counter_q    <= row_counter_q + COORD_BITS'(1);
					end else begin
						column_counter_q <= col_inc[COORD_BITS-1:0];
					end
				end
				if (cmd.take) begin
					weight_accumulator_q <= weight_accumulator_q + ACC_W'(weight_s3);
					samples_taken_q      <= samples_taken_q + FIELD_W'(1);
				end
			end
		end
	end

	// Weighted color distance: squares, then factor products, then the threshold.
	assign color_dist = DIST_W'(prod_s2[0]) + DIST_W'(prod_s2[1]) + DIST_W'(prod_s2[2]);

	always_ff @(posedge clk) begin
		if (cmd.pix_load) begin
			pix_q     <= {pixel_val, pixel_sat, pixel_hue};
			pix_eof_q <= end_of_frame;
		end
		for (int k = 0; k < NUM_CHAN; k++) begin
			sq_s1[k] <= SQ_W'(
				(target_hsv_q[k*CHAN_W +: CHAN_W] >= pix_q[k*CHAN_W +: CHAN_W])
				? (target_hsv_q[k*CHAN_W +: CHAN_W] - pix_q[k*CHAN_W +: CHAN_W])
				: (pix_q[k*CHAN_W +: CHAN_W] - target_hsv_q[k*CHAN_W +: CHAN_W]))
				* SQ_W'(
				(target_hsv_q[k*CHAN_W +: CHAN_W] >= pix_q[k*CHAN_W +: CHAN_W])
				? (target_hsv_q[k*CHAN_W +: CHAN_W] - pix_q[k*CHAN_W +: CHAN_W])
				: (pix_q[k*CHAN_W +: CHAN_W] - target_hsv_q[k*CHAN_W +: CHAN_W]));
			prod_s2[k] <= PROD_W'(sq_s1[k]) * PROD_W'(channel_factors_q[k*FIELD_W +: FIELD_W]);
		end
		weight_s3 <= (color_dist > DIST_ONE) ? FIELD_W'(1) : max_weight_q;
		if (cmd.out_load) begin
			weight_total_q  <= weight_accumulator_q;
			color_present_q <= weight_accumulator_q >= detect_bound_q;
			samples_seen_q  <= samples_taken_q;
		end
	end

	assign st.pending_hit  = pending && !unreach && hit;
	assign st.pending_skip = pending && (unreach || behind);
	assign st.in_eof       = end_of_frame;
	assign st.pix_eof      = pix_eof_q;
	assign st.div_done     = div_done;

	assign weight_total  = weight_total_q;
	assign color_present = color_present_q;
	assign samples_seen  = samples_seen_q;

`ifndef SYNTHESIS
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sample_index_q <= lat_count_q)
		else $error("sample index ran past the latched sample count");

	a_col_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(lat_width_q == '0) ? (col_off_q == '0) : (col_off_q < lat_width_q))
		else $error("column offset left the region width");
`endif

endmodule

// ===== design/scpd_ctrl.sv =====
// Controller state machine: region setup sequence, per-pixel sample scan, result hand-off.
// Depends on scpd_pkg for the command and status structs.
module scpd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 cfg_we,
	input  scpd_pkg::scpd_stat_t st,
	output scpd_pkg::scpd_cmd_t  cmd
);
	import scpd_pkg::*;

	localparam logic [3:0] ST_LAT_AREA   = 4'd0;
	localparam logic [3:0] ST_LAT_STEP   = 4'd1;
	localparam logic [3:0] ST_LAT_STEPW  = 4'd2;
	localparam logic [3:0] ST_LAT_SPLIT  = 4'd3;
	localparam logic [3:0] ST_LAT_SPLITW = 4'd4;
	localparam logic [3:0] ST_RUN        = 4'd5;
	localparam logic [3:0] ST_SQ         = 4'd6;
	localparam logic [3:0] ST_PROD       = 4'd7;
	localparam logic [3:0] ST_WGT        = 4'd8;
	localparam logic [3:0] ST_SCAN       = 4'd9;
	localparam logic [3:0] ST_EMIT       = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       in_frame_q;
	logic       in_frame_d;
	logic       out_valid_q;
	logic       out_free;
	logic       relatch;
	logic       finish;
	logic       eof_sel;

	assign out_free = !out_valid_q || !out_stall;
	// Any register write before the first pixel of a frame restarts region setup.
	assign relatch  = cfg_we && !in_frame_q;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		in_frame_d = in_frame_q;
		in_stall   = 1'b1;
		finish     = 1'b0;
		eof_sel    = 1'b0;
		unique case (state_q)
			ST_LAT_AREA: begin
				cmd.lat_load = 1'b1;
				state_d      = ST_LAT_STEP;
			end
			ST_LAT_STEP: begin
				cmd.div_start = 1'b1;
				state_d       = ST_LAT_STEPW;
			end
			ST_LAT_STEPW: begin
				if (st.div_done) begin
					cmd.step_cap = 1'b1;
					state_d      = ST_LAT_SPLIT;
				end
			end
			ST_LAT_SPLIT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = ST_LAT_SPLITW;
			end
			ST_LAT_SPLITW: begin
				cmd.div_sel = 1'b1;
				if (st.div_done) begin
					cmd.split_cap = 1'b1;
					state_d       = ST_RUN;
				end
			end
			ST_RUN: begin
				in_stall = relatch;
				if (in_valid && !relatch) begin
					cmd.pix_load = 1'b1;
					if (st.pending_hit || st.pending_skip) begin
						state_d = ST_SQ;
					end else begin
						finish  = 1'b1;
						eof_sel = st.in_eof;
					end
				end
			end
			ST_SQ: begin
				state_d = ST_PROD;
			end
			ST_PROD: begin
				state_d = ST_WGT;
			end
			ST_WGT: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (st.pending_skip) begin
					cmd.adv_sample = 1'b1;
				end else if (st.pending_hit) begin
					cmd.take       = 1'b1;
					cmd.adv_sample = 1'b1;
				end else begin
					finish  = 1'b1;
					eof_sel = st.pix_eof;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.out_load    = 1'b1;
					cmd.frame_clear = 1'b1;
					in_frame_d      = 1'b0;
					state_d         = ST_LAT_AREA;
				end
			end
			default: begin
				state_d = ST_LAT_AREA;
			end
		endcase

		// The pixel is done with its samples: close the frame or step the raster.
		if (finish) begin
			if (eof_sel) begin
				if (out_free) begin
					cmd.out_load    = 1'b1;
					cmd.frame_clear = 1'b1;
					in_frame_d      = 1'b0;
					state_d         = ST_LAT_AREA;
				end else begin
					state_d = ST_EMIT;
				end
			end else begin
				cmd.adv_pos = 1'b1;
				in_frame_d  = 1'b1;
				state_d     = ST_RUN;
			end
		end

		if (relatch && (state_q == ST_LAT_AREA || state_q == ST_LAT_STEP ||
			state_q == ST_LAT_STEPW || state_q == ST_LAT_SPLIT ||
			state_q == ST_LAT_SPLITW || state_q == ST_RUN)) begin
			cmd.step_cap  = 1'b0;
			cmd.split_cap = 1'b0;
			state_d       = ST_LAT_AREA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LAT_AREA;
			in_frame_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_frame_q <= in_frame_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (state_q == ST_RUN))
		else $error("pixel transaction taken outside the run state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register loaded while a stalled result waits");

	a_setup_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ST_LAT_AREA))
		else $error("region setup did not follow the end of a frame");
`endif

endmodule

// ===== design/sampled_color_presence_detector_top.sv =====
// Sampled color presence detector: pixel input channel, frame result channel, config port.
// Depends on scpd_pkg, scpd_datapath (with scpd_div) and scpd_ctrl.
//
// Usage:
//   Pixels arrive in raster order on in_valid/in_stall with hue, saturation, value and
//   end_of_frame; a transaction completes when in_valid is high and in_stall is low.
//   One result per frame leaves on out_valid/out_stall, taken from the end_of_frame pixel.
//   A pixel on which no pending sample is taken or dropped is done when it is accepted.
//   Otherwise it passes the accept state, the weighting pipeline of squares, factor
//   products and threshold, and a scan state that takes or drops one pending sample at a
//   time and then closes the pixel. The frame result is registered once its last pixel is
//   done and no older result waits. Region setup (region area, step = area /
//   sample_count, step split into rows and columns) runs one shared 32-step divider
//   twice; in_stall is high meanwhile. It runs after reset, after every end_of_frame
//   pixel and after a register write made before the first pixel of a frame.
//   Reset loads the register defaults and clears the counters, then runs region setup.
//   Pixels keep being accepted while a result waits on out_stall; a further end_of_frame
//   pixel holds the block until the waiting result has been taken.
//   Registers are written on cfg_we; they are expected to change only when the block is idle.
module sampled_color_presence_detector_top #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [scpd_pkg::CHAN_W-1:0]     pixel_hue,
	input  logic [scpd_pkg::CHAN_W-1:0]     pixel_sat,
	input  logic [scpd_pkg::CHAN_W-1:0]     pixel_val,
	input  logic                            end_of_frame,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [scpd_pkg::ACC_W-1:0]      weight_total,
	output logic                            color_present,
	output logic [scpd_pkg::FIELD_W-1:0]    samples_seen,
	input  logic                            cfg_we,
	input  logic [scpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scpd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import scpd_pkg::*;

	scpd_cmd_t  cmd;
	scpd_stat_t st;

	scpd_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel_hue     (pixel_hue),
		.pixel_sat     (pixel_sat),
		.pixel_val     (pixel_val),
		.end_of_frame  (end_of_frame),
		.cmd           (cmd),
		.st            (st),
		.weight_total  (weight_total),
		.color_present (color_present),
		.samples_seen  (samples_seen)
	);

	scpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.st        (st),
		.cmd       (cmd)
	);

endmodule
